// ===== design/sierpinski_triangle_generator_top_macros.svh =====
// Assertion macros used by the checker file of the Sierpinski leaf generator.
// Depends on an aclk clock and an aresetn reset being visible where a macro is used.
`ifndef SIERPINSKI_TRIANGLE_GENERATOR_TOP_MACROS_SVH
`define SIERPINSKI_TRIANGLE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define STG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stg_pkg.sv =====
// Shared constants, types and helpers of the Sierpinski leaf generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package stg_pkg;

    localparam int MAX_DEPTH = 10;
    localparam int MAX_SIZE  = 4096;

    localparam int DEPTH_W = 4;
    localparam int SIZE_W  = 13;
    localparam int CFG_W   = SIZE_W;
    localparam int COORD_W = $clog2(MAX_SIZE);
    localparam int LVL_W   = $clog2(MAX_DEPTH);
    localparam int EFF_W   = $clog2(MAX_DEPTH + 1);
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = ((6 * COORD_W + 7) / 8) * 8;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(1);
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(512);

    typedef enum logic [0:0] {
        REG_DEPTH = 1'b0,
        REG_IMAGE_SIZE = 1'b1
    } cfg_addr_t;

    typedef enum logic [1:0] {
        DIG_FIRST  = 2'd0,
        DIG_SECOND = 2'd1,
        DIG_THIRD  = 2'd2
    } digit_t;

    typedef struct packed {
        logic             start;
        logic             step;
        logic             load_out;
        logic [LVL_W-1:0] level;
    } cmd_t;

    typedef struct packed {
        logic [EFF_W-1:0] eff_depth;
    } status_t;

    function automatic logic [COORD_W-1:0] midpoint(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic [COORD_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COORD_W:1];
    endfunction

endpackage

// ===== design/sierpinski_triangle_generator_top.sv =====
// Top level of the Sierpinski leaf generator: joins the controller and the datapath.
// Depends on stg_pkg, stg_ctrl and stg_datapath.
//
// Channel   Direction  Contents
// s_        in         request: restart flag
// m_        out        leaf: six vertex coordinates, tlast on the final leaf
// cfg_      in         register writes: depth, image_size
//
// A request loads the root triangle and advances the path; then the midpoint logic runs
// one level per cycle for each of the D levels (D, the effective depth, is at most 10),
// then the leaf moves into the output register once it is free or its leaf is taken.
// A new request is taken while a finished leaf still waits in the output register.
// Reset is synchronous and active low; it restores depth 1 and image size 512.
module sierpinski_triangle_generator_top
    import stg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [0] restart, upper bits zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // x_top, y_top, x_left, y_left, x_right, y_right
    output logic                m_tlast,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wr_data
);

    cmd_t    cmd;
    status_t status;

    stg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    stg_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .restart     (s_tdata[0]),
        .cmd         (cmd),
        .status      (status),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== design/stg_datapath.sv =====
// Datapath of the Sierpinski leaf generator: configuration registers, path digits,
// the working triangle with its midpoint unit, and the output register. Uses stg_pkg.
module stg_datapath
    import stg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                restart,
    input  cmd_t                cmd,
    output status_t             status,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic [DEPTH_W-1:0] depth_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic               started_reg;
    digit_t             digits_reg [MAX_DEPTH];
    digit_t             digits_next [MAX_DEPTH];

    logic [COORD_W-1:0] tx_reg, ty_reg, lx_reg, ly_reg, rx_reg, ry_reg;
    logic               last_reg;
    logic [COORD_W-1:0] o_tx_reg, o_ty_reg, o_lx_reg, o_ly_reg, o_rx_reg, o_ry_reg;
    logic               o_last_reg;

    logic [EFF_W-1:0]   eff_depth;
    logic [SIZE_W-1:0]  size_eff;
    logic [COORD_W-1:0] s_m1;
    logic [COORD_W-1:0] m0x, m0y, m1x, m1y, m2x;
    digit_t             dig;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= DEPTH_RESET;
            size_reg  <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr_t'(cfg_addr))
                REG_DEPTH:      depth_reg <= cfg_wr_data[DEPTH_W-1:0];
                REG_IMAGE_SIZE: size_reg  <= cfg_wr_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(depth_reg) > MAX_DEPTH) begin
            eff_depth = EFF_W'(MAX_DEPTH);
        end else begin
            eff_depth = EFF_W'(depth_reg);
        end
        if (size_reg < SIZE_W'(2)) begin
            size_eff = SIZE_W'(2);
        end else if (int'(size_reg) > MAX_SIZE) begin
            size_eff = SIZE_W'(MAX_SIZE);
        end else begin
            size_eff = size_reg;
        end
        s_m1 = COORD_W'(size_eff - SIZE_W'(1));
    end

    assign status.eff_depth = eff_depth;

    // The path advances as a base-3 counter whose least significant digit is the deepest level.
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
            digits_next[i] = digits_reg[i];
            if (i < int'(eff_depth)) begin
                if (carry) begin
                    digits_next[i] = (digits_reg[i] == DIG_THIRD) ? DIG_FIRST :
                                     digit_t'(digits_reg[i] + 2'd1);
                end
                carry = carry & (digits_reg[i] == DIG_THIRD);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
        end else if (cmd.start) begin
            started_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            for (int i = 0; i < MAX_DEPTH; i++) begin
                digits_reg[i] <= (restart || !started_reg) ? DIG_FIRST : digits_next[i];
            end
        end
    end

    assign dig = digits_reg[cmd.level];
    assign m0x = midpoint(tx_reg, lx_reg);
    assign m0y = midpoint(ty_reg, ly_reg);
    assign m1x = midpoint(tx_reg, rx_reg);
    assign m1y = midpoint(ty_reg, ry_reg);
    assign m2x = midpoint(lx_reg, rx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            tx_reg   <= s_m1 >> 1;
            ty_reg   <= COORD_W'(1);
            lx_reg   <= COORD_W'(1);
            ly_reg   <= s_m1;
            rx_reg   <= s_m1;
            ry_reg   <= s_m1;
            last_reg <= 1'b1;
        end else if (cmd.step) begin
            last_reg <= last_reg & (dig == DIG_THIRD);
            case (dig)
                DIG_FIRST: begin
                    lx_reg <= m0x;
                    ly_reg <= m0y;
                    rx_reg <= m1x;
                    ry_reg <= m1y;
                end
                DIG_SECOND: begin
                    tx_reg <= m0x;
                    ty_reg <= m0y;
                    rx_reg <= m2x;
                    ry_reg <= ly_reg;
                end
                default: begin
                    tx_reg <= m1x;
                    ty_reg <= m1y;
                    lx_reg <= m2x;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            o_tx_reg   <= tx_reg;
            o_ty_reg   <= ty_reg;
            o_lx_reg   <= lx_reg;
            o_ly_reg   <= ly_reg;
            o_rx_reg   <= rx_reg;
            o_ry_reg   <= ry_reg;
            o_last_reg <= last_reg;
        end
    end

    assign m_tdata = M_DATA_W'({o_ry_reg, o_rx_reg, o_ly_reg, o_lx_reg, o_ty_reg, o_tx_reg});
    assign m_tlast = o_last_reg;

endmodule

// ===== design/stg_ctrl.sv =====
// Controller of the Sierpinski leaf generator: request handshake, level sequencing
// and result valid. Drives the datapath by command signals; uses stg_pkg.
module stg_ctrl
    import stg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output cmd_t    cmd,
    input  status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            level_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        level_next   = level_reg;
        s_tready     = 1'b0;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        cmd.level    = level_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.start  = 1'b1;
                    level_next = '0;
                    state_next = (status.eff_depth == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (EFF_W'(level_reg) == status.eff_depth - EFF_W'(1)) begin
                    state_next = ST_DONE;
                end else begin
                    level_next = level_reg + LVL_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== design/stg_checker.sv =====
// Port-level checker of the Sierpinski leaf generator, bound to the top level.
// Depends on stg_pkg and the assertion macro header.
`include "sierpinski_triangle_generator_top_macros.svh"

module stg_checker
    import stg_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    `STG_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled leaf changed")
    `STG_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `STG_ASSERT_NEXT(a_no_early_leaf, s_tvalid && s_tready, !$rose(m_tvalid), "leaf out too early")
    `STG_ASSERT_NOW(a_empty_after_reset, !$past(aresetn), !m_tvalid, "valid leaf after reset")

endmodule

bind sierpinski_triangle_generator_top stg_checker u_stg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
